### hw/rtl/insert_copy_command_code_assert.svh
// Assertion macros used by the RTL of the command code block
`ifndef INSERT_COPY_COMMAND_CODE_ASSERT_SVH
`define INSERT_COPY_COMMAND_CODE_ASSERT_SVH

`ifndef SYNTHESIS
`define ICC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("command code assertion failed");
`define ICC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("command code assertion failed");
`else
`define ICC_ASSERT_IMP(lbl, ante, cons)
`define ICC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/icc_pkg.sv
`timescale 1ns / 1ps
package icc_pkg;

  localparam int NUM_RANGES = 24;
  localparam int LEN_W      = 25;
  localparam int IDX_W      = 5;
  localparam int NBITS_W    = 5;
  localparam int EXTRA_W    = 24;
  localparam int CODE_W     = 10;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [NBITS_W-1:0] nbits_t;
  typedef logic [EXTRA_W-1:0] extra_t;
  typedef logic [CODE_W-1:0]  code_t;

  localparam len_t INS_OFF [NUM_RANGES] = '{
    25'd0,    25'd1,    25'd2,    25'd3,    25'd4,    25'd5,
    25'd6,    25'd8,    25'd10,   25'd14,   25'd18,   25'd26,
    25'd34,   25'd50,   25'd66,   25'd98,   25'd130,  25'd194,
    25'd322,  25'd578,  25'd1090, 25'd2114, 25'd6210, 25'd22594
  };

  localparam nbits_t INS_NBITS [NUM_RANGES] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1,  5'd1,  5'd2,  5'd2,  5'd3,  5'd3,
    5'd4, 5'd4, 5'd5, 5'd5, 5'd6, 5'd7, 5'd8,  5'd9,  5'd10, 5'd12, 5'd14, 5'd24
  };

  localparam len_t CPY_OFF [NUM_RANGES] = '{
    25'd2,    25'd3,    25'd4,    25'd5,    25'd6,    25'd7,
    25'd8,    25'd9,    25'd10,   25'd12,   25'd14,   25'd18,
    25'd22,   25'd30,   25'd38,   25'd54,   25'd70,   25'd102,
    25'd134,  25'd198,  25'd326,  25'd582,  25'd1094, 25'd2118
  };

  localparam nbits_t CPY_NBITS [NUM_RANGES] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1,  5'd1,  5'd2,  5'd2,
    5'd3, 5'd3, 5'd4, 5'd4, 5'd5, 5'd5, 5'd6, 5'd7, 5'd8,  5'd9,  5'd10, 5'd24
  };

  // First length beyond the last range of each kind
  localparam len_t INS_LIMIT = 25'd16799810;
  localparam len_t CPY_LIMIT = 25'd16779334;
  localparam len_t CPY_ZERO_SUBST = 25'd4;

  function automatic logic [3:0] pair_code(input logic [3:0] sel);
    logic [3:0] r;
    case (sel)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd2;
      4'd4:    r = 4'd3;
      4'd5:    r = 4'd6;
      4'd6:    r = 4'd5;
      4'd7:    r = 4'd7;
      4'd8:    r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/insert_copy_command_code.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  insert_len[24:0], copy_len[24:0]
// out_     output     out_valid/out_stall command_code[9:0], insert_nbits[4:0],
//                                        insert_extra[23:0], copy_nbits[4:0],
//                                        copy_extra[23:0], length_error
//
// One word enters per cycle while in_stall is low, passing through three register stages:
// range compares, range index encode, offset subtract and code assembly.
// Synchronous active-low reset clears the stage valid bits only.
// A stall passes back combinationally through the full stages; empty stages keep filling while the output waits.
`include "insert_copy_command_code_assert.svh"

module insert_copy_command_code
  import icc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  len_t   in_insert_len,
  input  len_t   in_copy_len,
  output logic   out_valid,
  input  logic   out_stall,
  output code_t  out_command_code,
  output nbits_t out_insert_nbits,
  output extra_t out_insert_extra,
  output nbits_t out_copy_nbits,
  output extra_t out_copy_extra,
  output logic   out_length_error
);

  logic adv1, adv2, adv3;

  // stage 1
  logic                  v1_r;
  len_t                  ins1_r, ins1_nxt, cpy1_r, cpy1_nxt;
  logic [NUM_RANGES-1:0] ins_ge_r, ins_ge_nxt, cpy_ge_r, cpy_ge_nxt;
  logic                  ins_ovf_r, ins_ovf_nxt, cpy_ovf_r, cpy_ovf_nxt;

  // stage 2
  logic v2_r;
  len_t ins2_r, cpy2_r;
  idx_t ip2_r, ip2_nxt, cp2_r, cp2_nxt;
  logic err2_r, err2_nxt;

  // stage 3
  logic   v3_r;
  code_t  code_r, code_nxt;
  nbits_t inb_r, inb_nxt, cnb_r, cnb_nxt;
  extra_t iex_r, iex_nxt, cex_r, cex_nxt;
  logic   err3_r;

  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    ins1_nxt    = in_insert_len;
    cpy1_nxt    = (in_copy_len == '0) ? CPY_ZERO_SUBST : in_copy_len;
    ins_ovf_nxt = ins1_nxt >= INS_LIMIT;
    cpy_ovf_nxt = cpy1_nxt >= CPY_LIMIT;
    for (int i = 0; i < NUM_RANGES; i++) begin
      ins_ge_nxt[i] = ins1_nxt >= INS_OFF[i];
      cpy_ge_nxt[i] = cpy1_nxt >= CPY_OFF[i];
    end
  end

  always_comb begin
    ip2_nxt = '0;
    cp2_nxt = '0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (ins_ge_r[i]) ip2_nxt = IDX_W'(i);
      if (cpy_ge_r[i]) cp2_nxt = IDX_W'(i);
    end
    err2_nxt = ins_ovf_r || cpy_ovf_r || !cpy_ge_r[0];
  end

  always_comb begin
    logic [1:0] ihi, chi;
    logic [3:0] sel;
    len_t       idiff, cdiff;
    ihi   = ip2_r[IDX_W-1:3];
    chi   = cp2_r[IDX_W-1:3];
    sel   = {2'b00, ihi} + {1'b0, ihi, 1'b0} + {2'b00, chi};
    idiff = ins2_r - INS_OFF[ip2_r];
    cdiff = cpy2_r - CPY_OFF[cp2_r];
    if (err2_r) begin
      code_nxt = '0;
      inb_nxt  = '0;
      iex_nxt  = '0;
      cnb_nxt  = '0;
      cex_nxt  = '0;
    end else begin
      code_nxt = {pair_code(sel), ip2_r[2:0], cp2_r[2:0]};
      inb_nxt  = INS_NBITS[ip2_r];
      iex_nxt  = idiff[EXTRA_W-1:0];
      cnb_nxt  = CPY_NBITS[cp2_r];
      cex_nxt  = cdiff[EXTRA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ins1_r    <= ins1_nxt;
      cpy1_r    <= cpy1_nxt;
      ins_ge_r  <= ins_ge_nxt;
      cpy_ge_r  <= cpy_ge_nxt;
      ins_ovf_r <= ins_ovf_nxt;
      cpy_ovf_r <= cpy_ovf_nxt;
    end
    if (adv2) begin
      ins2_r <= ins1_r;
      cpy2_r <= cpy1_r;
      ip2_r  <= ip2_nxt;
      cp2_r  <= cp2_nxt;
      err2_r <= err2_nxt;
    end
    if (adv3) begin
      code_r <= code_nxt;
      inb_r  <= inb_nxt;
      iex_r  <= iex_nxt;
      cnb_r  <= cnb_nxt;
      cex_r  <= cex_nxt;
      err3_r <= err2_r;
    end
  end

  assign out_valid        = v3_r;
  assign out_command_code = code_r;
  assign out_insert_nbits = inb_r;
  assign out_insert_extra = iex_r;
  assign out_copy_nbits   = cnb_r;
  assign out_copy_extra   = cex_r;
  assign out_length_error = err3_r;

  `ICC_ASSERT_IMP(a_err_zero, out_valid && out_length_error,
                  out_command_code == '0 && out_insert_nbits == '0
                  && out_insert_extra == '0 && out_copy_nbits == '0 && out_copy_extra == '0)
  `ICC_ASSERT_IMP(a_ins_extra_fits, out_valid && !out_length_error,
                  (LEN_W'(out_insert_extra) >> out_insert_nbits) == '0)
  `ICC_ASSERT_IMP(a_cpy_extra_fits, out_valid && !out_length_error,
                  (LEN_W'(out_copy_extra) >> out_copy_nbits) == '0)
  `ICC_ASSERT_NEXT(a_s2_hold, v2_r && !adv2, v2_r && $stable(ip2_r) && $stable(cp2_r))

endmodule

### verif/icc_code_checker.sv
`timescale 1ns / 1ps
module icc_code_checker
  import icc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall,
  input  len_t   in_insert_len,
  input  len_t   in_copy_len,
  input  logic   out_valid,
  input  logic   out_stall,
  input  code_t  out_command_code,
  input  nbits_t out_insert_nbits,
  input  extra_t out_insert_extra,
  input  nbits_t out_copy_nbits,
  input  extra_t out_copy_extra,
  input  logic   out_length_error,
  output int     n_pending,
  output int     n_failures,
  output int     n_words,
  output int     n_range_errors
);

  localparam int unsigned INS_BASE [NUM_RANGES] = '{
    0, 1, 2, 3, 4, 5, 6, 8, 10, 14, 18, 26,
    34, 50, 66, 98, 130, 194, 322, 578, 1090, 2114, 6210, 22594
  };
  localparam int unsigned INS_XBITS [NUM_RANGES] = '{
    0, 0, 0, 0, 0, 0, 1, 1, 2, 2, 3, 3,
    4, 4, 5, 5, 6, 7, 8, 9, 10, 12, 14, 24
  };
  localparam int unsigned CPY_BASE [NUM_RANGES] = '{
    2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 14, 18,
    22, 30, 38, 54, 70, 102, 134, 198, 326, 582, 1094, 2118
  };
  localparam int unsigned CPY_XBITS [NUM_RANGES] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 2,
    3, 3, 4, 4, 5, 5, 6, 7, 8, 9, 10, 24
  };
  localparam int unsigned PAIR_OF_SEL [9] = '{0, 1, 4, 2, 3, 6, 5, 7, 8};
  localparam int unsigned COPY_ZERO_AS = 4;

  typedef struct packed {
    code_t  code;
    nbits_t ins_nbits;
    extra_t ins_extra;
    nbits_t cpy_nbits;
    extra_t cpy_extra;
    logic   err;
  } cmd_word_t;

  cmd_word_t pending_codes [$];
  int fail_cnt  = 0;
  int word_cnt  = 0;
  int range_cnt = 0;

  function automatic int unsigned range_of(input bit copy_kind, input int unsigned len);
    int unsigned lo;
    int unsigned hi;
    for (int i = 0; i < NUM_RANGES; i++) begin
      lo = copy_kind ? CPY_BASE[i] : INS_BASE[i];
      hi = lo + (32'd1 << (copy_kind ? CPY_XBITS[i] : INS_XBITS[i]));
      if (len >= lo && len < hi) return i;
    end
    return NUM_RANGES;
  endfunction

  function automatic cmd_word_t encode_command(input len_t ins_len, input len_t cpy_len);
    cmd_word_t   w;
    int unsigned ins;
    int unsigned cpy;
    int unsigned ip;
    int unsigned cp;
    int unsigned sel;
    w   = '0;
    ins = ins_len;
    cpy = (cpy_len == '0) ? COPY_ZERO_AS : cpy_len;
    ip  = range_of(1'b0, ins);
    cp  = range_of(1'b1, cpy);
    if (ip == NUM_RANGES || cp == NUM_RANGES) begin
      w.err = 1'b1;
      return w;
    end
    sel         = 3 * (ip / 8) + cp / 8;
    w.code      = code_t'(PAIR_OF_SEL[sel] * 64 + (ip % 8) * 8 + cp % 8);
    w.ins_nbits = nbits_t'(INS_XBITS[ip]);
    w.ins_extra = extra_t'(ins - INS_BASE[ip]);
    w.cpy_nbits = nbits_t'(CPY_XBITS[cp]);
    w.cpy_extra = extra_t'(cpy - CPY_BASE[cp]);
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_cnt++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0d want %0d", word_cnt, field, got, want));
  endtask

  always @(posedge clk) begin
    cmd_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_codes.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_codes.pop_front();
          compare_field("command_code", 32'(out_command_code), 32'(want.code));
          compare_field("insert_nbits", 32'(out_insert_nbits), 32'(want.ins_nbits));
          compare_field("insert_extra", 32'(out_insert_extra), 32'(want.ins_extra));
          compare_field("copy_nbits", 32'(out_copy_nbits), 32'(want.cpy_nbits));
          compare_field("copy_extra", 32'(out_copy_extra), 32'(want.cpy_extra));
          compare_field("length_error", 32'(out_length_error), 32'(want.err));
          word_cnt++;
        end
      end
      if (in_valid && !in_stall) begin
        want = encode_command(in_insert_len, in_copy_len);
        pending_codes.push_back(want);
        if (want.err) range_cnt++;
      end
    end
    n_pending      <= pending_codes.size();
    n_failures     <= fail_cnt;
    n_words        <= word_cnt;
    n_range_errors <= range_cnt;
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import icc_pkg::*;

  logic   clk              = 1'b0;
  logic   rst_n            = 1'b0;
  logic   in_valid         = 1'b0;
  logic   in_stall;
  len_t   in_insert_len    = '0;
  len_t   in_copy_len      = '0;
  logic   out_valid;
  logic   out_stall        = 1'b0;
  code_t  out_command_code;
  nbits_t out_insert_nbits;
  extra_t out_insert_extra;
  nbits_t out_copy_nbits;
  extra_t out_copy_extra;
  logic   out_length_error;

  int n_pending;
  int n_failures;
  int n_words;
  int n_range_errors;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always #5 clk = ~clk;

  insert_copy_command_code dut (.*);

  icc_code_checker checker_i (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic issue_command(input len_t ins, input len_t cpy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_insert_len <= ins;
    in_copy_len   <= cpy;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic await_all_codes();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  function automatic len_t pick_insert_len();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(NUM_RANGES - 1);
    if (r < 65) return INS_OFF[k] + len_t'($urandom & ((32'd1 << INS_NBITS[k]) - 1));
    if (r < 80)
      return ($urandom_range(1) != 0) ? INS_OFF[k]
                                      : INS_OFF[k] + len_t'((32'd1 << INS_NBITS[k]) - 1);
    if (r < 88) return len_t'($urandom_range(200));
    if (r < 92) return INS_LIMIT + len_t'($urandom_range(3));
    return len_t'($urandom);
  endfunction

  function automatic len_t pick_copy_len();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(NUM_RANGES - 1);
    if (r < 5) return '0;
    if (r < 8) return len_t'(1);
    if (r < 65) return CPY_OFF[k] + len_t'($urandom & ((32'd1 << CPY_NBITS[k]) - 1));
    if (r < 80)
      return ($urandom_range(1) != 0) ? CPY_OFF[k]
                                      : CPY_OFF[k] + len_t'((32'd1 << CPY_NBITS[k]) - 1);
    if (r < 88) return len_t'($urandom_range(200));
    if (r < 92) return CPY_LIMIT + len_t'($urandom_range(3));
    return len_t'($urandom);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(25'd0, 25'd0);
    issue_command(25'd0, 25'd2);
    issue_command(25'd0, 25'd1);
    issue_command(25'd1, 25'd3);
    issue_command(25'd5, 25'd9);
    issue_command(25'd6, 25'd10);
    issue_command(25'd65, 25'd37);
    issue_command(25'd130, 25'd70);
    issue_command(25'd2114, 25'd1094);
    issue_command(25'd6209, 25'd1093);
    issue_command(25'd22593, 25'd2117);
    issue_command(25'd22594, 25'd2118);
    issue_command(25'd16799809, 25'd16779333);
    issue_command(25'd16799810, 25'd4);
    issue_command(25'd0, 25'd16779334);
    issue_command(25'h1FFFFFF, 25'h1FFFFFF);
    issue_command(25'd16777216, 25'd16777215);
    issue_command(25'h0AAAAAA, 25'h1555555);
    issue_command(25'h1000000, 25'h0555555);
    issue_command(25'h0555555, 25'h0AAAAAA);
    await_all_codes();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      repeat (95) issue_command(pick_insert_len(), pick_copy_len());
      if (ph == 1) await_all_codes();
    end

    await_all_codes();
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("checked %0d command words, %0d of them with a length out of range,",
             n_words, n_range_errors);
    $display("across range edges and four mixes of sender idling and receiver stalling");
    if (n_failures == 0 && n_pending == 0) begin
      $display("insert_copy_command_code test passed");
    end else begin
      $display("insert_copy_command_code test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("insert_copy_command_code test failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/icc_pkg.sv
hw/rtl/insert_copy_command_code.sv
verif/icc_code_checker.sv
verif/tb_top.sv
